>>> design/dmsc_pkg.sv
package dmsc_pkg;

    localparam int INDEX_BITS_DEFAULT = 16;
    localparam int KEY_W = 64;
    localparam int PAYLOAD_W = 58;
    localparam int RAM_DEPTH_DEFAULT = 1 << INDEX_BITS_DEFAULT;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_PROBE = 1'b1;

    localparam logic [1:0] BOUND_EXACT = 2'd0;

    typedef struct packed {
        logic signed [15:0] static_eval;
        logic [1:0]         bound;
        logic [7:0]         depth;
        logic [15:0]        move;
        logic signed [15:0] score;
    } payload_t;

endpackage

>>> design/dmsc_ram.sv
module dmsc_ram #(
    parameter int WIDTH = dmsc_pkg::PAYLOAD_W,
    parameter int DEPTH = dmsc_pkg::RAM_DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/direct_mapped_search_cache_unit.sv
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    operation key score best_move search_depth
//                                            bound_kind static_eval
// result   out        out_valid / out_ready  slot_key slot_score slot_move slot_depth
//                                            slot_bound slot_static_eval key_match was_written
//
// Each item is handled in order: its slot is read from the key and payload RAMs,
// then the store is decided and written back; the next item is accepted only after that.
// After reset a clearing pass writes zeros to every slot;
// in_ready stays low throughout.
// The result register lets the next item be accepted in the cycle its predecessor
// is taken; a stalled result holds in_ready low.
module direct_mapped_search_cache_unit #(
    parameter int INDEX_BITS = dmsc_pkg::INDEX_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic [dmsc_pkg::KEY_W-1:0]  key,
    input  logic signed [15:0]          score,
    input  logic [15:0]                 best_move,
    input  logic [7:0]                  search_depth,
    input  logic [1:0]                  bound_kind,
    input  logic signed [15:0]          static_eval,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dmsc_pkg::KEY_W-1:0]  slot_key,
    output logic signed [15:0]          slot_score,
    output logic [15:0]                 slot_move,
    output logic [7:0]                  slot_depth,
    output logic [1:0]                  slot_bound,
    output logic signed [15:0]          slot_static_eval,
    output logic                        key_match,
    output logic                        was_written
);

    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic [INDEX_BITS-1:0]         clear_idx_reg, clear_idx_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          op_reg;
    logic [dmsc_pkg::KEY_W-1:0]    key_reg;
    dmsc_pkg::payload_t            item_reg;

    logic [dmsc_pkg::KEY_W-1:0]    slot_key_reg;
    dmsc_pkg::payload_t            slot_pay_reg;
    logic                          key_match_reg;
    logic                          was_written_reg;

    logic                          in_fire;
    logic                          ram_we;
    logic [INDEX_BITS-1:0]         ram_addr;
    logic [dmsc_pkg::KEY_W-1:0]    key_wdata;
    logic [dmsc_pkg::KEY_W-1:0]    key_rdata;
    dmsc_pkg::payload_t            pay_wdata;
    logic [dmsc_pkg::PAYLOAD_W-1:0] pay_rdata;
    dmsc_pkg::payload_t            old_pay;

    logic                          match;
    logic                          drop;
    logic                          replace;
    logic                          do_write;
    logic signed [9:0]             new_depth_s;
    logic signed [9:0]             old_depth_m1;
    logic [9:0]                    new_depth_x3;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign old_pay = dmsc_pkg::payload_t'(pay_rdata);
    assign match   = (key_rdata == key_reg);

    assign new_depth_s  = $signed({2'b00, item_reg.depth});
    assign old_depth_m1 = $signed({2'b00, old_pay.depth}) - 10'sd1;
    assign new_depth_x3 = {2'b00, item_reg.depth} + {1'b0, item_reg.depth, 1'b0};

    assign drop     = (item_reg.bound != dmsc_pkg::BOUND_EXACT) && match
                      && (new_depth_s < old_depth_m1);
    assign replace  = (item_reg.bound == dmsc_pkg::BOUND_EXACT)
                      || (new_depth_x3 > {2'b00, old_pay.depth});
    assign do_write = (op_reg == dmsc_pkg::OP_STORE) && !drop && replace;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = key_reg[INDEX_BITS-1:0];
        key_wdata = key_reg;
        pay_wdata = item_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clear_idx_reg;
                key_wdata = '0;
                pay_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_addr = key[INDEX_BITS-1:0];
            end
            ST_LOOKUP:
            begin
                ram_we = do_write;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + 1'b1;
                if (&clear_idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the accepted item for the write-back cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg               <= operation;
            key_reg              <= key;
            item_reg.score       <= score;
            item_reg.move        <= best_move;
            item_reg.depth       <= search_depth;
            item_reg.bound       <= bound_kind;
            item_reg.static_eval <= static_eval;
        end
        if (state_reg == ST_LOOKUP)
        begin
            slot_key_reg    <= key_rdata;
            slot_pay_reg    <= old_pay;
            key_match_reg   <= match;
            was_written_reg <= do_write;
        end
    end

    dmsc_ram #(
        .WIDTH (dmsc_pkg::KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (key_wdata),
        .rdata (key_rdata)
    );

    dmsc_ram #(
        .WIDTH (dmsc_pkg::PAYLOAD_W),
        .DEPTH (SLOT_COUNT)
    ) u_pay_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pay_wdata),
        .rdata (pay_rdata)
    );

    assign out_valid        = out_valid_reg;
    assign slot_key         = slot_key_reg;
    assign slot_score       = slot_pay_reg.score;
    assign slot_move        = slot_pay_reg.move;
    assign slot_depth       = slot_pay_reg.depth;
    assign slot_bound       = slot_pay_reg.bound;
    assign slot_static_eval = slot_pay_reg.static_eval;
    assign key_match        = key_match_reg;
    assign was_written      = was_written_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_LOOKUP))
        else $error("accepted item not looked up");

    a_lookup_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |=> (out_valid && (state_reg == ST_IDLE)))
        else $error("lookup produced no result");

    a_probe_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_LOOKUP) && (op_reg == dmsc_pkg::OP_PROBE)) |-> !ram_we)
        else $error("probe wrote the table");

    a_lookup_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !out_valid_reg)
        else $error("result register busy at write-back");

endmodule

>>> bench/tb_direct_mapped_search_cache_unit.sv
`timescale 1ns / 1ps

module tb_direct_mapped_search_cache_unit;

    localparam int IDX_W = dmsc_pkg::INDEX_BITS_DEFAULT;
    localparam int STALL_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 310;

    typedef struct packed {
        logic               op;
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic [7:0]         depth;
        logic [1:0]         bound;
        logic signed [15:0] seval;
    } request_t;

    typedef struct packed {
        logic [63:0]        key;
        dmsc_pkg::payload_t pay;
        logic               hit;
        logic               written;
    } slot_view_t;

    class slot_ledger;
        logic [63:0]        keys [int unsigned];
        dmsc_pkg::payload_t entries [int unsigned];
        slot_view_t         awaited_views [$];
        int                 errors;
        int                 stores;
        int                 overwrites;
        int                 probes;
        int                 hits;

        function void note_request(request_t r);
            int unsigned slot;
            slot_view_t  view;
            int          d;
            int          held;
            bit          refused;
            slot = 32'(r.key[IDX_W-1:0]);
            view.key = keys.exists(slot) ? keys[slot] : '0;
            view.pay = entries.exists(slot) ? entries[slot] : '0;
            view.hit = (view.key == r.key);
            view.written = 1'b0;
            d = int'(r.depth);
            held = int'(view.pay.depth);
            if (r.op == dmsc_pkg::OP_STORE)
            begin
                stores++;
                refused = (r.bound != dmsc_pkg::BOUND_EXACT) && view.hit && (d < held - 1);
                if (!refused && (r.bound == dmsc_pkg::BOUND_EXACT || d * 3 > held))
                begin
                    keys[slot] = r.key;
                    entries[slot] = '{static_eval: r.seval, bound: r.bound, depth: r.depth,
                                      move: r.move, score: r.score};
                    view.written = 1'b1;
                    overwrites++;
                end
            end
            else
            begin
                probes++;
                if (view.hit)
                    hits++;
            end
            awaited_views.insert(awaited_views.size(), view);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s expected %h got %h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_view(slot_view_t seen);
            slot_view_t want;
            if (awaited_views.size() == 0)
            begin
                $display("%0t: unexpected result, key %h", $time, seen.key);
                errors++;
                return;
            end
            want = awaited_views.pop_front();
            compare_field("slot_key", want.key, seen.key);
            compare_field("slot_score", 64'(want.pay.score), 64'(seen.pay.score));
            compare_field("slot_move", 64'(want.pay.move), 64'(seen.pay.move));
            compare_field("slot_depth", 64'(want.pay.depth), 64'(seen.pay.depth));
            compare_field("slot_bound", 64'(want.pay.bound), 64'(seen.pay.bound));
            compare_field("slot_static_eval", 64'(want.pay.static_eval),
                          64'(seen.pay.static_eval));
            compare_field("key_match", 64'(want.hit), 64'(seen.hit));
            compare_field("was_written", 64'(want.written), 64'(seen.written));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               operation = dmsc_pkg::OP_STORE;
    logic [63:0]        key = '0;
    logic signed [15:0] score = '0;
    logic [15:0]        best_move = '0;
    logic [7:0]         search_depth = '0;
    logic [1:0]         bound_kind = dmsc_pkg::BOUND_EXACT;
    logic signed [15:0] static_eval = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [63:0]        slot_key;
    logic signed [15:0] slot_score;
    logic [15:0]        slot_move;
    logic [7:0]         slot_depth;
    logic [1:0]         slot_bound;
    logic signed [15:0] slot_static_eval;
    logic               key_match;
    logic               was_written;

    slot_ledger  ledger;
    slot_view_t  seen_view;
    int          sender_idle_pct = 30;
    int          receiver_idle_pct = 65;
    int          quiet_cycles = 0;
    logic [IDX_W-1:0] idx_pool [6];
    logic [63-IDX_W:0] tag_pool [4];

    direct_mapped_search_cache_unit #(
        .INDEX_BITS(IDX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .key(key),
        .score(score),
        .best_move(best_move),
        .search_depth(search_depth),
        .bound_kind(bound_kind),
        .static_eval(static_eval),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot_key(slot_key),
        .slot_score(slot_score),
        .slot_move(slot_move),
        .slot_depth(slot_depth),
        .slot_bound(slot_bound),
        .slot_static_eval(slot_static_eval),
        .key_match(key_match),
        .was_written(was_written)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_view.key = slot_key;
            seen_view.pay = '{static_eval: slot_static_eval, bound: slot_bound,
                              depth: slot_depth, move: slot_move, score: slot_score};
            seen_view.hit = key_match;
            seen_view.written = was_written;
            ledger.check_view(seen_view);
        end
        out_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("direct_mapped_search_cache_unit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic request_t make_request(logic op, logic [63:0] k, logic signed [15:0] sc,
                                              logic [15:0] mv, logic [7:0] dp,
                                              logic [1:0] bd, logic signed [15:0] se);
        request_t r;
        r.op = op;
        r.key = k;
        r.score = sc;
        r.move = mv;
        r.depth = dp;
        r.bound = bd;
        r.seval = se;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.op = ($urandom_range(99) < 55) ? dmsc_pkg::OP_STORE : dmsc_pkg::OP_PROBE;
        if ($urandom_range(99) < 80)
            r.key = {tag_pool[$urandom_range(3)], idx_pool[$urandom_range(5)]};
        else
            r.key = {$urandom, $urandom};
        r.score = 16'($urandom);
        r.move = 16'($urandom);
        r.depth = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
        r.bound = 2'($urandom_range(3));
        r.seval = 16'($urandom);
        return r;
    endfunction

    function automatic request_t probe_request(logic [63:0] k);
        return make_request(dmsc_pkg::OP_PROBE, k, 16'sd0, 16'h0000, 8'd0,
                            dmsc_pkg::BOUND_EXACT, 16'sd0);
    endfunction

    task automatic send_request(input request_t r);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        operation <= r.op;
        key <= r.key;
        score <= r.score;
        best_move <= r.move;
        search_depth <= r.depth;
        bound_kind <= r.bound;
        static_eval <= r.seval;
        do @(posedge clk); while (!in_ready);
        ledger.note_request(r);
    endtask

    initial
    begin
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        ledger = new();
        k1 = 64'hA5A5_0000_0000_1234;
        k2 = 64'h5A5A_FFFF_0000_1234;
        k3 = 64'h0123_4567_89AB_7777;
        idx_pool[0] = '0;
        tag_pool[0] = '0;
        for (int i = 1; i < 6; i++)
            idx_pool[i] = IDX_W'($urandom);
        for (int i = 1; i < 4; i++)
            tag_pool[i] = (64 - IDX_W)'({$urandom, $urandom});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty slots, extremes, the replacement and refusal rules, same-slot back to back
        send_request(probe_request('0));
        send_request(probe_request('1));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, -16'sd32768, 16'h0000, 8'd0,
                                  dmsc_pkg::BOUND_EXACT, 16'sd32767));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, 16'sd32767, 16'hFFFF, 8'd255, 2'd1,
                                  -16'sd32768));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, 16'sd5, 16'h1111, 8'd10, 2'd2,
                                  16'sd7));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, 16'sd6, 16'h2222, 8'd10,
                                  dmsc_pkg::BOUND_EXACT, 16'sd8));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, -16'sd9, 16'h3333, 8'd9, 2'd3,
                                  -16'sd1));
        send_request(make_request(dmsc_pkg::OP_STORE, k1, 16'sd1, 16'h4444, 8'd2, 2'd1,
                                  16'sd2));
        send_request(make_request(dmsc_pkg::OP_STORE, k2, 16'sd3, 16'h5555, 8'd2, 2'd1,
                                  16'sd4));
        send_request(make_request(dmsc_pkg::OP_STORE, k2, 16'sd4, 16'h6666, 8'd4, 2'd2,
                                  16'sd5));
        send_request(probe_request(k1));
        send_request(probe_request(k2));
        send_request(make_request(dmsc_pkg::OP_STORE, '0, 16'sd12, 16'h7777, 8'd0, 2'd1,
                                  16'sd13));
        send_request(make_request(dmsc_pkg::OP_STORE, '0, 16'sd14, 16'h8888, 8'd1, 2'd1,
                                  16'sd15));
        send_request(probe_request('0));
        send_request(make_request(dmsc_pkg::OP_STORE, k3, -16'sd2, 16'hABCD, 8'd5,
                                  dmsc_pkg::BOUND_EXACT, 16'sd3));
        send_request(probe_request(k3));
        send_request(make_request(dmsc_pkg::OP_STORE, '1, 16'sd32767, 16'hFFFF, 8'd255, 2'd3,
                                  16'sd32767));
        send_request(probe_request('1));

        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 65 : 0;
            receiver_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 30 : 0;
            repeat (RANDOM_PER_PHASE)
                send_request(random_request());
        end
        in_valid <= 1'b0;

        while (ledger.awaited_views.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d stores (%0d overwrote their slot) and %0d probes (%0d key hits),",
                 ledger.stores, ledger.overwrites, ledger.probes, ledger.hits);
        $display("over three sender/receiver stall mixes with heavy slot sharing.");
        if (ledger.errors == 0)
            $display("direct_mapped_search_cache_unit regression: pass");
        else
            $display("direct_mapped_search_cache_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/dmsc_pkg.sv
design/dmsc_ram.sv
design/direct_mapped_search_cache_unit.sv
bench/tb_direct_mapped_search_cache_unit.sv
